// File: sv/tprd_pkg.sv
`timescale 1ns / 1ps

package tprd_pkg;

    localparam int RING_AW      = 13;
    localparam int RING_DEPTH   = 1 << RING_AW;
    localparam int BURST_FRAMES = 16;
    localparam int FRAME_CNT_W  = $clog2(BURST_FRAMES + 1);
    localparam int CREDIT_W     = 18;
    localparam int ALU_W        = CREDIT_W + 1;
    localparam int COST_W       = 14;
    localparam int BURST_SHIFT  = $clog2(BURST_FRAMES);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [11:0] RATE_RESET    = 12'd100;
    localparam logic [2:0]  FRAME_RESET   = 3'd1;
    localparam logic [7:0]  SILENCE_RESET = 8'h80;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE    = 2'd0,
        CFG_FRAME   = 2'd1,
        CFG_SILENCE = 2'd2,
        CFG_UNUSED  = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COST,
        ST_ADD,
        ST_CAP,
        ST_CHECK,
        ST_LOOK,
        ST_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
    } ring_req_t;

endpackage

// File: sv/tprd_alu.sv
`timescale 1ns / 1ps

module tprd_alu (
    input  tprd_pkg::alu_op_t               alu_op,
    input  logic [tprd_pkg::ALU_W-1:0]      a,
    input  logic [tprd_pkg::ALU_W-1:0]      b,
    output logic [tprd_pkg::ALU_W-1:0]      result,
    output logic                            ge
);

    logic                          sub;
    logic [tprd_pkg::ALU_W-1:0]    b_in;
    logic [tprd_pkg::ALU_W:0]      full;

    always_comb begin
        sub    = (alu_op == tprd_pkg::ALU_SUB);
        b_in   = sub ? ~b : b;
        full   = {1'b0, a} + {1'b0, b_in} + {{tprd_pkg::ALU_W{1'b0}}, sub};
        result = full[tprd_pkg::ALU_W-1:0];
        ge     = sub & full[tprd_pkg::ALU_W];
    end

endmodule

// File: sv/tprd_ring.sv
`timescale 1ns / 1ps

module tprd_ring (
    input  logic                 aclk,
    input  tprd_pkg::ring_req_t  req,
    output logic [7:0]           rd_data
);

    logic [7:0] mem [tprd_pkg::RING_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/time_paced_ring_drain_unit.sv
// Write, flush and op 3 beats are handled in the idle state and send nothing.
// A tick beat steps through accept, cost, credit add and cap, then per frame through a credit
// check (check and look states) and per byte through a registered ring read and an output load; a
// tick that sends no frame ends after one more credit check. The first byte is registered at the
// output after the cost, add, cap, check, look, read and emit states; a stalled output holds the sequencer.
// Synchronous active-low reset restores pointers, credit, sequencer and config; ring needs no clear.
`timescale 1ns / 1ps

module time_paced_ring_drain_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic [7:0]                          s_data_byte,
    input  logic [15:0]                         s_elapsed_ticks,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_is_silence,
    output logic                                m_last_of_tick,
    output logic [12:0]                         m_ring_fill,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tprd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tprd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = tprd_pkg::RING_AW;
    localparam int FW = tprd_pkg::FRAME_CNT_W;
    localparam int CW = tprd_pkg::CREDIT_W;
    localparam int XW = tprd_pkg::ALU_W;
    localparam int KW = tprd_pkg::COST_W;

    tprd_pkg::state_t   state_reg, state_next;
    logic [11:0]        rate_reg;
    logic [2:0]         frame_reg;
    logic [7:0]         silence_reg;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]      credit_reg, credit_next;
    logic [XW-1:0]      acc_reg, acc_next;
    logic [KW-1:0]      cost_reg, cost_next;
    logic [FW-1:0]      frames_reg, frames_next;
    logic [1:0]         byte_idx_reg, byte_idx_next;
    logic               from_ring_reg, from_ring_next;
    logic               more_reg, more_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_sil_reg, m_sil_next;
    logic               m_last_reg, m_last_next;
    logic [12:0]        m_fill_reg, m_fill_next;

    tprd_pkg::alu_op_t  alu_op;
    logic [XW-1:0]      alu_a, alu_b, alu_res;
    logic               alu_ge;
    tprd_pkg::ring_req_t ring_req;
    logic [7:0]         ring_data;

    logic [2:0]         unit;
    logic [11:0]        rate_eff;
    logic [1:0]         unit_last;
    logic [AW-1:0]      used;
    logic [CW-1:0]      cap;
    logic               accept;
    logic               out_free;
    tprd_pkg::op_t      op;

    tprd_alu u_alu (
        .alu_op (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .ge     (alu_ge)
    );

    tprd_ring u_ring (
        .aclk    (aclk),
        .req     (ring_req),
        .rd_data (ring_data)
    );

    always_comb begin
        unit      = (frame_reg == 3'd0) ? 3'd1 : ((frame_reg > 3'd4) ? 3'd4 : frame_reg);
        rate_eff  = (rate_reg == 12'd0) ? 12'd1 : rate_reg;
        unit_last = 2'(unit - 3'd1);
        used      = wr_ptr_reg - rd_ptr_reg;
        cap       = CW'({cost_reg, {tprd_pkg::BURST_SHIFT{1'b0}}});
        op        = tprd_pkg::op_t'(s_op);
        accept    = s_valid && s_ready;
        out_free  = !m_valid_reg || m_ready;
    end

    assign s_ready        = (state_reg == tprd_pkg::ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_is_silence   = m_sil_reg;
    assign m_last_of_tick = m_last_reg;
    assign m_ring_fill    = m_fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg    <= tprd_pkg::RATE_RESET;
            frame_reg   <= tprd_pkg::FRAME_RESET;
            silence_reg <= tprd_pkg::SILENCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tprd_pkg::cfg_idx_t'(cfg_index))
                tprd_pkg::CFG_RATE:    rate_reg    <= cfg_data[11:0];
                tprd_pkg::CFG_FRAME:   frame_reg   <= cfg_data[2:0];
                tprd_pkg::CFG_SILENCE: silence_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tprd_pkg::ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            credit_reg    <= '0;
            frames_reg    <= '0;
            byte_idx_reg  <= '0;
            from_ring_reg <= 1'b0;
            more_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            credit_reg    <= credit_next;
            frames_reg    <= frames_next;
            byte_idx_reg  <= byte_idx_next;
            from_ring_reg <= from_ring_next;
            more_reg      <= more_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        cost_reg   <= cost_next;
        m_byte_reg <= m_byte_next;
        m_sil_reg  <= m_sil_next;
        m_last_reg <= m_last_next;
        m_fill_reg <= m_fill_next;
    end

    always_comb begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        credit_next    = credit_reg;
        acc_next       = acc_reg;
        cost_next      = cost_reg;
        frames_next    = frames_reg;
        byte_idx_next  = byte_idx_reg;
        from_ring_next = from_ring_reg;
        more_next      = more_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_sil_next     = m_sil_reg;
        m_last_next    = m_last_reg;
        m_fill_next    = m_fill_reg;
        alu_op         = tprd_pkg::ALU_SUB;
        alu_a          = {1'b0, credit_reg};
        alu_b          = XW'(cost_reg);
        ring_req       = '{wr_en: 1'b0, wr_addr: wr_ptr_reg, wr_data: s_data_byte,
                           rd_en: 1'b0, rd_addr: rd_ptr_reg};

        unique case (state_reg)
            tprd_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        tprd_pkg::OP_WRITE: begin
                            if (used != {AW{1'b1}}) begin
                                ring_req.wr_en = 1'b1;
                                wr_ptr_next    = wr_ptr_reg + 1'b1;
                            end
                        end
                        tprd_pkg::OP_TICK: begin
                            acc_next   = XW'(s_elapsed_ticks);
                            state_next = tprd_pkg::ST_COST;
                        end
                        tprd_pkg::OP_FLUSH: rd_ptr_next = wr_ptr_reg;
                        default: ;
                    endcase
                end
            end
            tprd_pkg::ST_COST: begin
                cost_next  = KW'(rate_eff) * KW'(unit);
                state_next = tprd_pkg::ST_ADD;
            end
            tprd_pkg::ST_ADD: begin
                alu_op     = tprd_pkg::ALU_ADD;
                alu_b      = acc_reg;
                acc_next   = alu_res;
                state_next = tprd_pkg::ST_CAP;
            end
            tprd_pkg::ST_CAP: begin
                alu_a       = acc_reg;
                alu_b       = {1'b0, cap};
                credit_next = alu_ge ? cap : acc_reg[CW-1:0];
                frames_next = '0;
                state_next  = tprd_pkg::ST_CHECK;
            end
            tprd_pkg::ST_CHECK: begin
                if (alu_ge && (frames_reg < FW'(tprd_pkg::BURST_FRAMES))) begin
                    credit_next    = alu_res[CW-1:0];
                    frames_next    = frames_reg + 1'b1;
                    from_ring_next = (used >= AW'(unit));
                    byte_idx_next  = '0;
                    state_next     = tprd_pkg::ST_LOOK;
                end else begin
                    state_next = tprd_pkg::ST_IDLE;
                end
            end
            tprd_pkg::ST_LOOK: begin
                more_next  = alu_ge && (frames_reg < FW'(tprd_pkg::BURST_FRAMES));
                state_next = tprd_pkg::ST_RD;
            end
            tprd_pkg::ST_RD: begin
                ring_req.rd_en = from_ring_reg;
                state_next     = tprd_pkg::ST_EMIT;
            end
            tprd_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (from_ring_reg) begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                    m_valid_next = 1'b1;
                    m_byte_next  = from_ring_reg ? ring_data : silence_reg;
                    m_sil_next   = !from_ring_reg;
                    m_last_next  = (byte_idx_reg == unit_last) && !more_reg;
                    m_fill_next  = 13'(wr_ptr_reg - rd_ptr_next);
                    if (byte_idx_reg == unit_last) begin
                        state_next = more_reg ? tprd_pkg::ST_CHECK : tprd_pkg::ST_IDLE;
                    end else begin
                        byte_idx_next = byte_idx_reg + 1'b1;
                        state_next    = tprd_pkg::ST_RD;
                    end
                end
            end
            default: state_next = tprd_pkg::ST_IDLE;
        endcase
    end

    a_ring_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tprd_pkg::ST_EMIT) && from_ring_reg |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("ring read while empty");

    a_frames_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frames_reg <= FW'(tprd_pkg::BURST_FRAMES))
        else $error("frame count past burst limit");

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == tprd_pkg::ST_EMIT) && (state_reg == tprd_pkg::ST_IDLE)
        |-> (m_valid_reg && m_last_reg))
        else $error("tick ended without last beat");

    a_no_drain_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tprd_pkg::ST_IDLE) && !(s_valid && s_op == tprd_pkg::OP_FLUSH)
        |=> (rd_ptr_reg == $past(rd_ptr_reg)))
        else $error("read pointer moved outside a tick or flush");

endmodule
